// ===== rtl/core/wmbd_pkg.sv =====
// ----------------------------------------------------------------------------
// wmbd_pkg: shared types and codes for the weight map brush dab block
// Beat payload structs, request and blend mode codes, divider sizing.
// ----------------------------------------------------------------------------
package wmbd_pkg;

    localparam logic [1:0] REQ_DAB   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [1:0] RES_DAB   = 2'd0;
    localparam logic [1:0] RES_READ  = 2'd1;
    localparam logic [1:0] RES_WRITE = 2'd2;

    localparam logic [1:0] MODE_ADD  = 2'd0;
    localparam logic [1:0] MODE_SUB  = 2'd1;

    // Divider: quotient bits, numerator and divisor widths
    localparam int DIV_QW = 17;
    localparam int DIV_DW = 24;
    localparam int DIV_NW = DIV_QW + DIV_DW;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [11:0]        radius;
        logic [15:0]        weight;
        logic [7:0]         hardness;
        logic [8:0]         opacity;
        logic [1:0]         paint_mode;
        logic [7:0]         pixel_value;
    } req_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] pixel_out;
        logic       addr_error;
    } rsp_t;

    typedef struct packed {
        logic [11:0] radius;
        logic [15:0] weight;
        logic [7:0]  hardness;
        logic [8:0]  opacity;
        logic [1:0]  paint_mode;
    } brush_t;

endpackage

// ===== rtl/core/wmbd_div.sv =====
// ----------------------------------------------------------------------------
// wmbd_div: iterative restoring divider
// One quotient bit per cycle; quotient must fit DIV_QW bits.
// ----------------------------------------------------------------------------
module wmbd_div
    import wmbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [DIV_QW-1:0] quo
);

    localparam int CNTW = $clog2(DIV_QW);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_QW-1:0] sh_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_DW:0] trial;
    logic [DIV_DW:0] diff;
    logic            ge;

    assign trial = {rem_reg, sh_reg[DIV_QW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(DIV_QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[DIV_NW-1:DIV_QW];
            sh_reg  <= num[DIV_QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            sh_reg  <= {sh_reg[DIV_QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

// ===== rtl/core/wmbd_blend.sv =====
// ----------------------------------------------------------------------------
// wmbd_blend: per-pixel falloff and blend sequencer
// One shared multiplier and the divider, stepped by a small state machine.
// ----------------------------------------------------------------------------
module wmbd_blend
    import wmbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  brush_t      brush,
    input  logic [12:0] dx_mag,
    input  logic [12:0] dy_mag,
    input  logic [7:0]  old_val,
    output logic        done,
    output logic        wr_en,
    output logic [7:0]  new_val
);

    localparam logic [3:0] B_IDLE = 4'd0;
    localparam logic [3:0] B_DY   = 4'd1;
    localparam logic [3:0] B_R2   = 4'd2;
    localparam logic [3:0] B_CMP  = 4'd3;
    localparam logic [3:0] B_DD   = 4'd4;
    localparam logic [3:0] B_FALL = 4'd5;
    localparam logic [3:0] B_HM   = 4'd6;
    localparam logic [3:0] B_Q1   = 4'd7;
    localparam logic [3:0] B_Q2   = 4'd8;
    localparam logic [3:0] B_P    = 4'd9;
    localparam logic [3:0] B_D    = 4'd10;
    localparam logic [3:0] B_RP   = 4'd11;
    localparam logic [3:0] B_FIN  = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic [24:0] mul_a;
    logic [16:0] mul_b;
    logic [41:0] prod_reg;
    logic [25:0] acc_reg;
    logic [25:0] n_reg;
    logic [16:0] dd_reg;
    logic [16:0] opa_reg;
    logic [24:0] p_reg;
    logic [40:0] delta_reg;

    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic              div_done;
    logic [DIV_QW-1:0] div_quo;

    logic        soft_side;
    logic [16:0] inv_dd;
    logic [9:0]  add_val;
    logic [40:0] sub_base;
    logic [40:0] sub_diff;
    logic [41:0] rep_sum;
    logic [9:0]  raw_val;

    wmbd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign soft_side = {1'b0, dd_reg} < {1'b0, brush.hardness, 8'b0};
    assign inv_dd    = 17'(18'd65536 - {1'b0, dd_reg});

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_IDLE:
            begin
                mul_a = 25'(dx_mag);
                mul_b = 17'(dx_mag);
            end
            B_DY:
            begin
                mul_a = 25'(dy_mag);
                mul_b = 17'(dy_mag);
            end
            B_R2:
            begin
                mul_a = 25'(brush.radius);
                mul_b = 17'(brush.radius);
            end
            B_FALL:
            begin
                mul_a = 25'(brush.hardness);
                mul_b = inv_dd;
            end
            B_P:
            begin
                mul_a = 25'(opa_reg);
                mul_b = 17'(brush.opacity);
            end
            B_D:
            begin
                mul_a = prod_reg[24:0];
                mul_b = 17'(brush.weight);
            end
            B_RP:
            begin
                mul_a = 25'(25'h1000000 - p_reg);
                mul_b = 17'(old_val);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider command select
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            B_CMP:
            begin
                div_start = n_reg <= 26'(prod_reg[23:0]);
                div_num   = DIV_NW'({n_reg[23:0], 16'b0});
                div_den   = prod_reg[23:0];
            end
            B_FALL:
            begin
                div_start = soft_side;
                div_num   = DIV_NW'({dd_reg, 8'b0});
                div_den   = DIV_DW'(brush.hardness);
            end
            B_HM:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'(prod_reg[23:0]);
                div_den   = DIV_DW'(9'd256 - {1'b0, brush.hardness});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (start) state_next = B_DY;
            B_DY:   state_next = B_R2;
            B_R2:   state_next = B_CMP;
            B_CMP:  state_next = (n_reg > 26'(prod_reg[23:0])) ? B_IDLE : B_DD;
            B_DD:   if (div_done) state_next = B_FALL;
            B_FALL: state_next = soft_side ? B_Q1 : B_HM;
            B_HM:   state_next = B_Q2;
            B_Q1:   if (div_done) state_next = B_P;
            B_Q2:   if (div_done) state_next = B_P;
            B_P:    state_next = B_D;
            B_D:    state_next = B_RP;
            B_RP:   state_next = B_FIN;
            B_FIN:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (state_reg == B_DY)
            acc_reg <= prod_reg[25:0];
        if (state_reg == B_R2)
            n_reg <= acc_reg + prod_reg[25:0];
        if (state_reg == B_DD && div_done)
            dd_reg <= div_quo;
        if (state_reg == B_Q1 && div_done)
            opa_reg <= 17'({1'b0, dd_reg} + 18'd65536 - {1'b0, div_quo});
        if (state_reg == B_Q2 && div_done)
            opa_reg <= div_quo;
        if (state_reg == B_D)
            p_reg <= prod_reg[24:0];
        if (state_reg == B_RP)
            delta_reg <= prod_reg[40:0];
    end

    // final blend; prod_reg holds old * (2^24 - p) here
    assign add_val  = {2'b0, old_val} + {1'b0, delta_reg[40:32]};
    assign sub_base = {1'b0, old_val, 32'b0};
    assign sub_diff = sub_base - delta_reg;
    assign rep_sum  = {1'b0, prod_reg[32:0], 8'b0} + {1'b0, delta_reg};

    always_comb
    begin
        case (brush.paint_mode)
            MODE_ADD: raw_val = add_val;
            MODE_SUB: raw_val = (delta_reg >= sub_base) ? 10'd0 : {2'b0, sub_diff[39:32]};
            default:  raw_val = rep_sum[41:32];
        endcase
    end

    assign done    = (state_reg == B_FIN) ||
                     (state_reg == B_CMP && n_reg > 26'(prod_reg[23:0]));
    assign wr_en   = state_reg == B_FIN;
    assign new_val = (raw_val[9:8] != 2'b0) ? 8'd255 : raw_val[7:0];

endmodule

// ===== rtl/core/weight_map_brush_dab_top.sv =====
// ----------------------------------------------------------------------------
// weight_map_brush_dab_top: soft round brush dab onto an 8-bit weight image
// Request decode, bounding box scan, image memory and result register.
// ----------------------------------------------------------------------------
// Dab: every box pixel is visited in turn; one outside the radius ends at the
//   radius compare, one inside it takes two divisions in the shared divider.
// Throughput: one request at a time; the next is taken once the result
//   is parked in the output register.
// Reset: a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT pixels, one
//   per cycle; no request is taken until it ends.
//   Config writes are taken throughout.
module weight_map_brush_dab_top
    import wmbd_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CW        = 14;   // signed pixel coordinate width

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_BOX  = 3'd2;
    localparam logic [2:0] S_PRD  = 3'd3;
    localparam logic [2:0] S_PST  = 3'd4;
    localparam logic [2:0] S_PWT  = 3'd5;
    localparam logic [2:0] S_RDW  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // image memory
    logic [7:0]    mem [MEM_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wdata;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] addr_reg;
    logic [8:0]    width_reg, height_reg;
    brush_t        brush_reg;
    logic signed [15:0] x_reg, y_reg;
    logic signed [CW-1:0] maxx_reg, miny_reg, maxy_reg;
    logic [CW-2:0] i_reg, j_reg;
    logic [12:0]   dx_reg, dy_reg;
    rsp_t          res_reg;
    rsp_t          rsp_reg;
    logic          rsp_valid_reg;

    logic [12:0]   effw, effh;
    logic signed [CW-1:0] px, py;
    logic          pix_out;
    logic          req_fire;

    logic signed [17:0]   xlo, xhi, ylo, yhi;
    logic signed [CW-1:0] minx_c, maxx_c, miny_c, maxy_c;
    logic signed [CW-1:0] wlim, hlim;
    logic signed [17:0]   dx_s, dy_s;

    logic       blend_start;
    logic       blend_done;
    logic       blend_wr;
    logic [7:0] blend_val;

    function automatic logic [AW-1:0] pix_addr(input logic [CW-2:0] x, input logic [CW-2:0] y);
        logic [31:0] lin;
        lin = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
        return lin[AW-1:0];
    endfunction

    // effective size: register capped by the storage
    assign effw = (13'(width_reg) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_reg);
    assign effh = (13'(height_reg) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_reg);
    assign wlim = $signed({1'b0, effw}) - 14'sd1;
    assign hlim = $signed({1'b0, effh}) - 14'sd1;

    // single pixel address: floor of Q12.4
    assign px      = CW'(req.pos_x >>> 4);
    assign py      = CW'(req.pos_y >>> 4);
    assign pix_out = px < 0 || py < 0 || px > wlim || py > hlim;

    assign req_ready = state_reg == S_IDLE;
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;

    // bounding box: floor(c - r) .. ceil(c + r), clipped
    assign xlo = 18'(x_reg) - $signed({6'b0, brush_reg.radius});
    assign xhi = 18'(x_reg) + $signed({6'b0, brush_reg.radius}) + 18'sd15;
    assign ylo = 18'(y_reg) - $signed({6'b0, brush_reg.radius});
    assign yhi = 18'(y_reg) + $signed({6'b0, brush_reg.radius}) + 18'sd15;

    always_comb
    begin
        minx_c = CW'(xlo >>> 4);
        maxx_c = CW'(xhi >>> 4);
        miny_c = CW'(ylo >>> 4);
        maxy_c = CW'(yhi >>> 4);
        if (minx_c < 0)
            minx_c = '0;
        if (miny_c < 0)
            miny_c = '0;
        if (maxx_c > wlim)
            maxx_c = wlim;
        if (maxy_c > hlim)
            maxy_c = hlim;
    end

    // offsets from centre in 1/16 pixel; within the box they stay under 2^13
    assign dx_s = $signed({1'b0, i_reg, 4'b0}) - 18'(x_reg);
    assign dy_s = $signed({1'b0, j_reg, 4'b0}) - 18'(y_reg);

    assign blend_start = state_reg == S_PST;

    wmbd_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (blend_start),
        .brush   (brush_reg),
        .dx_mag  (dx_reg),
        .dy_mag  (dy_reg),
        .old_val (rd_data_reg),
        .done    (blend_done),
        .wr_en   (blend_wr),
        .new_val (blend_val)
    );

    // memory port select
    always_comb
    begin
        mem_addr  = addr_reg;
        mem_we    = 1'b0;
        mem_wdata = blend_val;
        case (state_reg)
            S_CLR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                mem_wdata = 8'd0;
            end
            S_IDLE:
            begin
                mem_addr  = pix_addr(px[CW-2:0], py[CW-2:0]);
                mem_we    = req_fire && req.req_type == REQ_WRITE && !pix_out;
                mem_wdata = req.pixel_value;
            end
            S_PRD:
                mem_addr = pix_addr(i_reg, j_reg);
            S_PWT:
                mem_we = blend_done && blend_wr;
            default:
                mem_addr = addr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
                if (clr_reg == AW'(MEM_DEPTH - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (req_fire)
                begin
                    if (req.req_type == REQ_DAB && req.radius != 12'd0)
                        state_next = S_BOX;
                    else if (req.req_type == REQ_READ && !pix_out)
                        state_next = S_RDW;
                    else
                        state_next = S_OUT;
                end
            S_BOX:
                state_next = (minx_c > maxx_c || miny_c > maxy_c) ? S_OUT : S_PRD;
            S_PRD:
                state_next = S_PST;
            S_PST:
                state_next = S_PWT;
            S_PWT:
                if (blend_done)
                begin
                    if (j_reg == maxy_reg[CW-2:0] && i_reg == maxx_reg[CW-2:0])
                        state_next = S_OUT;
                    else
                        state_next = S_PRD;
                end
            S_RDW:
                state_next = S_OUT;
            S_OUT:
                if (!rsp_valid_reg || rsp_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            width_reg     <= 9'd256;
            height_reg    <= 9'd256;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  width_reg  <= cfg_data;
                    CFG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
            if (state_reg == S_OUT && (!rsp_valid_reg || rsp_ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload and scan registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (req_fire)
                begin
                    x_reg                <= req.pos_x;
                    y_reg                <= req.pos_y;
                    brush_reg.radius     <= req.radius;
                    brush_reg.weight     <= req.weight;
                    brush_reg.hardness   <= req.hardness;
                    brush_reg.opacity    <= (req.opacity > 9'd256) ? 9'd256 : req.opacity;
                    brush_reg.paint_mode <= req.paint_mode;
                    res_reg.pixel_out    <= 8'd0;
                    if (req.req_type == REQ_READ || req.req_type == REQ_WRITE)
                    begin
                        res_reg.result_kind <= (req.req_type == REQ_READ) ? RES_READ
                                                                          : RES_WRITE;
                        res_reg.addr_error  <= pix_out;
                    end
                    else
                    begin
                        res_reg.result_kind <= RES_DAB;
                        res_reg.addr_error  <= 1'b0;
                    end
                end
            S_BOX:
            begin
                i_reg    <= minx_c[CW-2:0];
                j_reg    <= miny_c[CW-2:0];
                maxx_reg <= maxx_c;
                miny_reg <= miny_c;
                maxy_reg <= maxy_c;
            end
            S_PRD:
            begin
                addr_reg <= pix_addr(i_reg, j_reg);
                dx_reg   <= dx_s[17] ? 13'(-dx_s) : dx_s[12:0];
                dy_reg   <= dy_s[17] ? 13'(-dy_s) : dy_s[12:0];
            end
            S_PWT:
                if (blend_done)
                begin
                    if (j_reg == maxy_reg[CW-2:0])
                    begin
                        j_reg <= miny_reg[CW-2:0];
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                end
            S_RDW:
                res_reg.pixel_out <= rd_data_reg;
            S_OUT:
                if (!rsp_valid_reg || rsp_ready)
                    rsp_reg <= res_reg;
            default:
                ;
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== dv/tb_weight_map_brush_dab_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_weight_map_brush_dab_top: self-checking bench for the brush dab block
// Queue-fed request driver, random response back-pressure and an in-order
// scoreboard fed by a local model of the weight image and the dab blend.
// ----------------------------------------------------------------------------
module tb_weight_map_brush_dab_top;
    import wmbd_pkg::*;

    localparam int IMG_W = 256;
    localparam int IMG_H = 256;
    localparam logic [1:0] REQ_NONE   = 2'd3;  // unused request code
    localparam logic [1:0] MODE_REPL  = 2'd2;
    localparam logic [1:0] MODE_ALT   = 2'd3;  // unused mode, blends as replace
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SPARE2 = 2'd2;
    localparam logic [1:0] CFG_SPARE3 = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    weight_map_brush_dab_top #(.MAX_WIDTH(IMG_W), .MAX_HEIGHT(IMG_H)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Model state: shadow image plus shadow size registers
    logic [7:0] shadow_img [0:IMG_W*IMG_H-1];
    logic [8:0] shadow_w;
    logic [8:0] shadow_h;

    req_t pending_reqs [$];     // beats waiting for the driver
    rsp_t expected_rsps [$];    // predicted responses, oldest first

    int queued_cnt   = 0;
    int accepted_cnt = 0;
    int errors       = 0;
    int n_dab        = 0;
    int n_read       = 0;
    int n_write      = 0;
    int n_rsp        = 0;
    int n_cfg        = 0;

    bit no_idle    = 0;   // both sides run flat out while set
    bit hold_start = 0;   // asks the receiver for one long stall
    int hold_cnt   = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------------
    function automatic longint eff_w();
        return (shadow_w < IMG_W) ? longint'(shadow_w) : longint'(IMG_W);
    endfunction

    function automatic longint eff_h();
        return (shadow_h < IMG_H) ? longint'(shadow_h) : longint'(IMG_H);
    endfunction

    // Stamp one soft round dab into the shadow image
    task automatic paint_shadow(input req_t q);
        longint x16, y16, r, minx, miny, maxx, maxy, dx, dy;
        longint unsigned r2, n, dd, opa, p, delta, old, base, val, h, op, w;
        begin
            x16 = q.pos_x;
            y16 = q.pos_y;
            r   = q.radius;
            r2  = q.radius * q.radius;
            h   = q.hardness;
            w   = q.weight;
            op  = (q.opacity > 9'd256) ? 256 : q.opacity;
            if (r != 0)
            begin
                // floor and ceil of the box edges, in whole pixels
                minx = (x16 - r) >>> 4;
                miny = (y16 - r) >>> 4;
                maxx = -((-(x16 + r)) >>> 4);
                maxy = -((-(y16 + r)) >>> 4);
                if (minx < 0) minx = 0;
                if (miny < 0) miny = 0;
                if (maxx > eff_w() - 1) maxx = eff_w() - 1;
                if (maxy > eff_h() - 1) maxy = eff_h() - 1;
                for (longint i = minx; i <= maxx; i++)
                begin
                    for (longint j = miny; j <= maxy; j++)
                    begin
                        dx = i * 16 - x16;
                        dy = j * 16 - y16;
                        n  = longint'(dx * dx) + longint'(dy * dy);
                        if (n <= r2)
                        begin
                            dd = (n << 16) / r2;
                            if (dd < 256 * h)
                                opa = dd + 65536 - (dd * 256) / h;
                            else
                                opa = (h * (65536 - dd)) / (256 - h);
                            p     = opa * op;
                            delta = p * w;
                            old   = shadow_img[j * IMG_W + i];
                            base  = old << 32;
                            if (q.paint_mode == MODE_ADD)
                                val = (base + delta) >> 32;
                            else if (q.paint_mode == MODE_SUB)
                                val = (delta >= base) ? 0 : ((base - delta) >> 32);
                            else
                                val = (((old * ((64'd1 << 24) - p)) << 8) + delta) >> 32;
                            if (val > 255) val = 255;
                            shadow_img[j * IMG_W + i] = val[7:0];
                        end
                    end
                end
            end
        end
    endtask

    // Work out the response for one accepted request and update the image
    task automatic predict_rsp(input req_t q);
        rsp_t   e;
        longint px, py;
        begin
            e  = '0;
            px = longint'(q.pos_x) >>> 4;
            py = longint'(q.pos_y) >>> 4;
            case (q.req_type)
                REQ_DAB:
                begin
                    paint_shadow(q);
                    n_dab++;
                end
                REQ_READ, REQ_WRITE:
                begin
                    e.result_kind = (q.req_type == REQ_READ) ? RES_READ : RES_WRITE;
                    if (px < 0 || py < 0 || px >= eff_w() || py >= eff_h())
                        e.addr_error = 1'b1;
                    else if (q.req_type == REQ_READ)
                        e.pixel_out = shadow_img[py * IMG_W + px];
                    else
                        shadow_img[py * IMG_W + px] = q.pixel_value;
                    if (q.req_type == REQ_READ) n_read++; else n_write++;
                end
                default: ;
            endcase
            expected_rsps.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver: presents queued beats, idles about 30% of free slots
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                predict_rsp(req);
                accepted_cnt++;
            end
            if (!req_valid || req_ready)
            begin
                if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 30))
                begin
                    req       <= pending_reqs.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response side: random ready, plus one long stall on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp_ready <= 1'b0;
        end
        else if (hold_start)
        begin
            hold_start = 0;
            hold_cnt   = 1500;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 30);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor / scoreboard
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_rsp++;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected response beat, actual %p", $realtime, rsp);
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (rsp.result_kind !== e.result_kind)
                begin
                    $display("%0t: result_kind expected %0d actual %0d",
                             $realtime, e.result_kind, rsp.result_kind);
                    errors++;
                end
                if (rsp.pixel_out !== e.pixel_out)
                begin
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $realtime, e.pixel_out, rsp.pixel_out);
                    errors++;
                end
                if (rsp.addr_error !== e.addr_error)
                begin
                    $display("%0t: addr_error expected %0d actual %0d",
                             $realtime, e.addr_error, rsp.addr_error);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic req_t mk_req(logic [1:0] t, logic [15:0] x, logic [15:0] y,
                                    logic [11:0] r, logic [15:0] w, logic [7:0] h,
                                    logic [8:0] op, logic [1:0] m, logic [7:0] pv);
        req_t q;
        q.req_type    = t;
        q.pos_x       = x;
        q.pos_y       = y;
        q.radius      = r;
        q.weight      = w;
        q.hardness    = h;
        q.opacity     = op;
        q.paint_mode  = m;
        q.pixel_value = pv;
        return q;
    endfunction

    task automatic push_req(input req_t q);
        pending_reqs.push_back(q);
        queued_cnt++;
    endtask

    // Random beat shaped to the current image size: mostly in-image
    // positions and small radii, now and then anything at all
    function automatic req_t rand_req();
        req_t        q;
        int unsigned sel;
        longint      span_x, span_y;
        q      = $urandom;
        sel    = $urandom_range(99);
        span_x = eff_w() * 16 + 64;
        span_y = eff_h() * 16 + 64;
        q.req_type = (sel < 42) ? REQ_DAB : (sel < 70) ? REQ_READ :
                     (sel < 95) ? REQ_WRITE : REQ_NONE;
        q.weight      = $urandom;
        q.hardness    = $urandom;
        q.opacity     = $urandom_range(511);
        q.paint_mode  = $urandom;
        q.pixel_value = $urandom;
        if ($urandom_range(99) < 85)
        begin
            q.pos_x = 16'($urandom_range(span_x - 1) - 32);
            q.pos_y = 16'($urandom_range(span_y - 1) - 32);
        end
        else
        begin
            q.pos_x = $urandom;
            q.pos_y = $urandom;
        end
        // Big radii only where the clipped box stays cheap
        if (eff_w() * eff_h() <= 1024 && $urandom_range(99) < 20)
            q.radius = $urandom;
        else
            q.radius = $urandom_range(64);
        return q;
    endfunction

    task automatic push_random(input int count);
        for (int k = 0; k < count; k++)
            push_req(rand_req());
    endtask

    // Wait until the block has nothing in flight
    task automatic wait_drained();
        wait (accepted_cnt == queued_cnt && expected_rsps.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [8:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) shadow_w = val;
        else if (idx == CFG_HEIGHT) shadow_h = val;
        n_cfg++;
    endtask

    task automatic set_size(input logic [8:0] w, input logic [8:0] h);
        wait_drained();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
    endtask

    // ------------------------------------------------------------------------
    // Limit on run time
    // ------------------------------------------------------------------------
    initial
    begin
        #40_000_000;
        $display("timeout with %0d responses outstanding", expected_rsps.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int k = 0; k < IMG_W * IMG_H; k++)
            shadow_img[k] = 8'd0;
        shadow_w  = 9'd256;
        shadow_h  = 9'd256;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rsp_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: pixel corners, out-of-range addresses, each blend mode,
        // zero radius, saturated opacity, hardness extremes, box off-image
        push_req(mk_req(REQ_WRITE, 16'd0, 16'd0, 0, 0, 0, 0, MODE_ADD, 8'hFF));
        push_req(mk_req(REQ_WRITE, 16'd4095, 16'd4095, 0, 0, 0, 0, MODE_ADD, 8'h5A));
        push_req(mk_req(REQ_READ, 16'd0, 16'd0, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_READ, 16'd4095, 16'd4095, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_WRITE, 16'h8000, 16'h8000, 0, 0, 0, 0, MODE_ADD, 8'hA5));
        push_req(mk_req(REQ_READ, 16'h7FFF, 16'd10, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_READ, 16'd20, 16'hFFFF, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_NONE, 16'h1234, 16'h0567, 12'hFFF, 16'hFFFF, 8'hFF,
                        9'h1FF, MODE_ALT, 8'hFF));
        push_req(mk_req(REQ_DAB, 16'd1600, 16'd1600, 0, 16'hFFFF, 8'd128, 9'd256,
                        MODE_ADD, 0));
        push_req(mk_req(REQ_DAB, 16'd648, 16'd648, 12'd48, 16'hFFFF, 8'd255, 9'd256,
                        MODE_ADD, 0));
        push_req(mk_req(REQ_DAB, 16'd648, 16'd648, 12'd32, 16'h4000, 8'd128, 9'h1FF,
                        MODE_SUB, 0));
        push_req(mk_req(REQ_DAB, 16'd650, 16'd645, 12'd40, 16'h8000, 8'd0, 9'd200,
                        MODE_REPL, 0));
        push_req(mk_req(REQ_DAB, 16'd600, 16'd700, 12'd24, 16'h1234, 8'd64, 9'd128,
                        MODE_ALT, 0));
        push_req(mk_req(REQ_DAB, 16'h8000, 16'h8000, 12'hFFF, 16'hFFFF, 8'd200,
                        9'd256, MODE_ADD, 0));
        push_req(mk_req(REQ_DAB, 16'h7FFF, 16'h7FFF, 12'hFFF, 16'hFFFF, 8'd200,
                        9'd256, MODE_ADD, 0));
        push_req(mk_req(REQ_DAB, 16'd3, 16'd5, 12'd40, 16'h00FF, 8'd100, 9'd0,
                        MODE_ADD, 0));
        push_req(mk_req(REQ_DAB, 16'd0, 16'd0, 12'd40, 16'h0100, 8'd100, 9'd256,
                        MODE_SUB, 0));
        push_req(mk_req(REQ_READ, 16'd648, 16'd648, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_READ, 16'd656, 16'd640, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_READ, 16'd630, 16'd662, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_READ, 16'd16, 16'd16, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_WRITE, 16'd56, 16'd116, 0, 0, 0, 0, MODE_ADD, 8'hA5));
        push_req(mk_req(REQ_READ, 16'd63, 16'd127, 0, 0, 0, 0, MODE_ADD, 0));

        // Small image: a full-size radius gets clipped hard; the receiver
        // stalls for a long stretch while the sender keeps offering
        set_size(9'd16, 9'd16);
        push_req(mk_req(REQ_DAB, 16'd128, 16'd128, 12'hFFF, 16'hFFFF, 8'd200, 9'd256,
                        MODE_ADD, 0));
        push_req(mk_req(REQ_READ, 16'd255, 16'd255, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_READ, 16'd256, 16'd0, 0, 0, 0, 0, MODE_ADD, 0));
        push_random(30);
        hold_start = 1;

        // Empty image, then the spare register indexes, which do nothing
        set_size(9'd0, 9'd0);
        push_req(mk_req(REQ_WRITE, 16'd0, 16'd0, 0, 0, 0, 0, MODE_ADD, 8'h11));
        push_req(mk_req(REQ_READ, 16'd0, 16'd0, 0, 0, 0, 0, MODE_ADD, 0));
        push_req(mk_req(REQ_DAB, 16'd8, 16'd8, 12'd64, 16'hFFFF, 8'd128, 9'd256,
                        MODE_ADD, 0));
        wait_drained();
        cfg_write(CFG_SPARE2, 9'h1FF);
        cfg_write(CFG_SPARE3, 9'h000);

        // One column, height register above the maximum
        set_size(9'd1, 9'h1FF);
        push_random(25);

        // Full size again, first flat out with no idling at all
        set_size(9'h1FF, 9'h100);
        no_idle = 1;
        push_random(18);
        wait_drained();
        no_idle = 0;
        push_random(18);

        // Odd size, ends with a sender pause until all responses are back
        set_size(9'd200, 9'd37);
        push_random(20);
        wait_drained();
        repeat (200) @(posedge clk);

        $display("Covered %0d dabs, %0d reads, %0d writes, %0d responses, %0d cfg writes",
                 n_dab, n_read, n_write, n_rsp, n_cfg);
        $display("Image sizes swept: 256x256, 16x16, empty, 1x256, 200x37");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== weight_map_brush_dab_top.f =====
rtl/core/wmbd_pkg.sv
rtl/core/wmbd_div.sv
rtl/core/wmbd_blend.sv
rtl/core/weight_map_brush_dab_top.sv
dv/tb_weight_map_brush_dab_top.sv
